// ===== hw/rtl/bws_pkg.sv =====
// Shared types, opcodes and controller/datapath interface structs for the bitmap window sort.
package bws_pkg;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DRAIN  = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] value;
	} req_t;

	typedef struct packed {
		logic [31:0] sorted_value;
		logic        done_res;
	} res_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic clr_start;
		logic clr_wr;
		logic ins_div;
		logic ins_rd;
		logic ins_wr;
		logic scan_rd;
		logic scan_adv;
		logic scan_hit;
		logic drn_done;
		logic idx_calc;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic exhausted;
		logic hit;
		logic last_word;
	} sts_t;

endpackage

// ===== hw/rtl/bws_dp.sv =====
// Datapath of the bitmap window sort: bitmap memory, scan cursor, divider and result register.
module bws_dp
	import bws_pkg::*;
#(
	parameter int MAP_BITS  = 65536,
	parameter int WORD_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  req_t        req,
	output res_t        res,
	input  cmd_t        cmd,
	output sts_t        sts
);

	localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int WCW       = $clog2(MAP_WORDS + 1);
	localparam int BW        = $clog2(WORD_BITS);
	localparam int OFFW      = $clog2(MAP_BITS);
	// Reciprocal of WORD_BITS, exact for every offset below 2**OFFW.
	localparam int SH        = OFFW + BW;
	localparam int RW        = OFFW + 2;
	localparam int PW        = OFFW + RW;
	localparam longint RECIP = (longint'(1) << SH) / WORD_BITS + 1;

	logic [WORD_BITS-1:0] mem [MAP_WORDS];
	logic [WORD_BITS-1:0] rdata_q;

	logic [31:0]          base_q;
	logic [OFFW-1:0]      off_q;
	logic                 win_q;
	logic [OFFW-1:0]      ins_word_q;
	logic [BW-1:0]        ins_bit_q;
	logic [WCW-1:0]       word_q;
	logic [BW-1:0]        bit_q;
	logic [AW-1:0]        clr_ptr_q;
	logic [WCW-1:0]       found_word_q;
	logic [BW-1:0]        found_bit_q;
	logic [OFFW-1:0]      idx_q;
	logic                 done_q;
	res_t                 res_q;

	logic [31:0]          offset;
	logic [PW-1:0]        quot_prod;
	logic [PW-1:0]        quot_shift;
	logic [OFFW-1:0]      word_base;
	logic [OFFW-1:0]      rem;
	logic [WCW-1:0]       word_inc;
	logic [WORD_BITS-1:0] low_mask;
	logic [WORD_BITS-1:0] masked;
	logic [WORD_BITS-1:0] lsb;
	logic [BW-1:0]        hit_bit;
	logic                 mem_re;
	logic [AW-1:0]        mem_raddr;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;

	assign offset     = req.value - base_q;
	assign quot_prod  = PW'(off_q) * PW'(RECIP);
	assign quot_shift = quot_prod >> SH;
	assign word_base  = ins_word_q * OFFW'(WORD_BITS);
	assign rem        = off_q - word_base;
	assign word_inc   = word_q + WCW'(1);

	assign low_mask = (WORD_BITS'(1) << bit_q) - WORD_BITS'(1);
	assign masked   = rdata_q & ~low_mask;
	assign lsb      = masked & (~masked + WORD_BITS'(1));

	always_comb begin
		hit_bit = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (lsb[i]) begin
				hit_bit = hit_bit | BW'(i);
			end
		end
	end

	assign mem_re    = cmd.ins_rd | cmd.scan_rd | cmd.scan_adv;
	assign mem_raddr = cmd.ins_rd ? ins_word_q[AW-1:0] :
	                   (cmd.scan_adv ? word_inc[AW-1:0] : word_q[AW-1:0]);
	assign mem_we    = cmd.clr_wr | (cmd.ins_wr & win_q);
	assign mem_waddr = cmd.clr_wr ? clr_ptr_q : ins_word_q[AW-1:0];
	assign mem_wdata = cmd.clr_wr ? '0 : (rdata_q | (WORD_BITS'(1) << ins_bit_q));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	// Control registers: window base, scan cursor and clear pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= '0;
			word_q    <= '0;
			bit_q     <= '0;
			clr_ptr_q <= '0;
		end else begin
			if (cfg_we) begin
				base_q <= cfg_wdata;
			end
			if (cmd.clr_start) begin
				word_q    <= '0;
				bit_q     <= '0;
				clr_ptr_q <= '0;
			end else if (cmd.clr_wr) begin
				clr_ptr_q <= sts.clr_last ? '0 : clr_ptr_q + AW'(1);
			end
			if (cmd.scan_adv) begin
				word_q <= word_inc;
				bit_q  <= '0;
			end else if (cmd.scan_hit) begin
				if (hit_bit == BW'(WORD_BITS - 1)) begin
					word_q <= word_inc;
					bit_q  <= '0;
				end else begin
					bit_q <= hit_bit + BW'(1);
				end
			end else if (cmd.drn_done) begin
				word_q <= WCW'(MAP_WORDS);
				bit_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			off_q <= offset[OFFW-1:0];
			win_q <= (offset < 32'(MAP_BITS));
		end
		if (cmd.ins_div) begin
			ins_word_q <= quot_shift[OFFW-1:0];
		end
		if (cmd.ins_rd) begin
			ins_bit_q <= rem[BW-1:0];
		end
		if (cmd.scan_hit) begin
			found_word_q <= word_q;
			found_bit_q  <= hit_bit;
			done_q       <= 1'b0;
		end else if (cmd.drn_done) begin
			done_q <= 1'b1;
		end
		if (cmd.idx_calc) begin
			idx_q <= OFFW'(found_word_q) * OFFW'(WORD_BITS) + OFFW'(found_bit_q);
		end
		if (cmd.out_load) begin
			if (done_q) begin
				res_q.sorted_value <= '0;
				res_q.done_res     <= 1'b1;
			end else begin
				res_q.sorted_value <= base_q + 32'(idx_q);
				res_q.done_res     <= 1'b0;
			end
		end
	end

	assign res           = res_q;
	assign sts.clr_last  = (clr_ptr_q == AW'(MAP_WORDS - 1));
	assign sts.exhausted = (word_q == WCW'(MAP_WORDS));
	assign sts.hit       = |masked;
	assign sts.last_word = (word_q == WCW'(MAP_WORDS - 1));

`ifndef SYNTHESIS
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(word_q <= WCW'(MAP_WORDS)) && ((word_q == WCW'(MAP_WORDS)) -> (bit_q == '0)))
		else $error("scan cursor outside the map");
	a_no_write_during_scan: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !(cmd.scan_rd || cmd.scan_adv || cmd.ins_rd))
		else $error("bitmap write collides with a read");
`endif

endmodule

// ===== hw/rtl/bws_ctrl.sv =====
// Controller state machine of the bitmap window sort.
module bws_ctrl
	import bws_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic [1:0] req_opcode,
	output logic       res_valid,
	input  logic       res_ready,
	output cmd_t       cmd,
	input  sts_t       sts
);

	typedef enum logic [8:0] {
		S_CLR     = 9'b000000001,
		S_IDLE    = 9'b000000010,
		S_INS_DIV = 9'b000000100,
		S_INS_RD  = 9'b000001000,
		S_INS_WR  = 9'b000010000,
		S_DRN_RD  = 9'b000100000,
		S_DRN_CHK = 9'b001000000,
		S_DRN_IDX = 9'b010000000,
		S_DRN_OUT = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   res_valid_q;
	logic   slot_free;

	assign slot_free = !res_valid_q || res_ready;
	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					case (req_opcode)
						OP_INSERT: state_d = S_INS_DIV;
						OP_DRAIN:  state_d = S_DRN_RD;
						OP_CLEAR: begin
							cmd.clr_start = 1'b1;
							state_d       = S_CLR;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_INS_DIV: begin
				cmd.ins_div = 1'b1;
				state_d     = S_INS_RD;
			end
			S_INS_RD: begin
				cmd.ins_rd = 1'b1;
				state_d    = S_INS_WR;
			end
			S_INS_WR: begin
				cmd.ins_wr = 1'b1;
				state_d    = S_IDLE;
			end
			S_DRN_RD: begin
				if (sts.exhausted) begin
					cmd.drn_done = 1'b1;
					state_d      = S_DRN_OUT;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d     = S_DRN_CHK;
				end
			end
			S_DRN_CHK: begin
				if (sts.hit) begin
					cmd.scan_hit = 1'b1;
					state_d      = S_DRN_IDX;
				end else if (sts.last_word) begin
					cmd.drn_done = 1'b1;
					state_d      = S_DRN_OUT;
				end else begin
					cmd.scan_adv = 1'b1;
				end
			end
			S_DRN_IDX: begin
				cmd.idx_calc = 1'b1;
				state_d      = S_DRN_OUT;
			end
			S_DRN_OUT: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;

`ifndef SYNTHESIS
	a_load_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> slot_free)
		else $error("result loaded over an untaken result");
	a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && req_opcode == OP_CLEAR) |=> (state_q == S_CLR))
		else $error("clear request did not start the sweep");
	a_result_from_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_DRN_OUT))
		else $error("result raised outside a drain");
`endif

endmodule

// ===== hw/rtl/bitmap_window_sort_core.sv =====
// Top level of the bitmap window sort: controller and datapath.
// A presence bitmap of MAP_BITS bits, held in a single-port-style memory of WORD_BITS-bit
// words, covers the values window_base .. window_base + MAP_BITS - 1 (modulo 2**32). Each
// request carries an opcode: an insert sets the bit for value minus window_base and is
// dropped when that offset is not below MAP_BITS; a drain returns the next present value
// at or after the scan cursor, or done_res = 1 with sorted_value = 0 once none is left;
// a clear zeroes the bitmap and the cursor. Only a drain produces a result. Requests are
// handled one at a time. An insert goes through offset capture, a reciprocal divide into
// word and bit, a memory read and a memory write before the next request is accepted.
// A drain scans bitmap words, one per cycle through the memory read port, until it
// finds a value, which it turns into an index, or runs off the end of the map; a drain
// that finds the map already exhausted reads no words. The result sits in an output
// register, so the next request is accepted while it waits; a drain that finishes while
// the previous result is still untaken holds until that one is taken. After reset and
// after every clear the memory is swept to zero, one word per cycle, over all
// ceil(MAP_BITS / WORD_BITS) words (1024 with the defaults); no request is accepted
// during the sweep, while window_base writes are taken at any time. Inserting below the
// cursor sets the bit, but it is never drained; the next clear zeroes it.
module bitmap_window_sort_core
	import bws_pkg::*;
#(
	parameter int MAP_BITS  = 65536,
	parameter int WORD_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req,
	output logic        res_valid,
	input  logic        res_ready,
	output res_t        res,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	// The controller sequences each request; the datapath owns the bitmap and all data registers.
	bws_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_opcode (req.opcode),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	bws_dp #(
		.MAP_BITS  (MAP_BITS),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.res       (res),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== sim/bitmap_window_sort_core_tb.sv =====
// Self-checking testbench for the bitmap window sort core: directed edge cases, then randomized sort passes.
module bitmap_window_sort_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bws_pkg::*;

	localparam int MAP_BITS  = 65536;
	localparam int WORD_BITS = 64;
	localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;

	// The package names only the three live opcodes; this one must be ignored by the core.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// An insert finishes after its divide, read and write steps and produces no result. This many
	// idle cycles after the last drain result covers it before the window base is moved.
	localparam int SETTLE_CYCLES = 16;

	// Requests that change or query the bitmap; ignored ones do not count.
	localparam int RANDOM_REQUESTS = 1700;

	// Worst case per request: a long sender gap, a long result stall, and a full 1024-word
	// scan or clear sweep. About 1800 requests at that worst case stay well within the limit.
	localparam longint CYCLE_LIMIT = 10_000_000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_t        req       = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	res_t        res;
	logic        cfg_we    = 1'b0;
	logic [31:0] cfg_wdata = '0;

	// Predicted state of the core: window base, presence bitmap and scan cursor.
	logic [31:0]          base_model = '0;
	bit [WORD_BITS-1:0]   map_model [MAP_WORDS];
	int unsigned          cursor_model = 0;

	// Drain results still owed by the core, oldest first.
	res_t drain_results_q [$];

	int     error_count   = 0;
	int     request_count = 0;
	int     stall_left    = 0;
	bit     req_throttle  = 1'b1;
	bit     res_throttle  = 1'b1;
	longint cycle_count   = 0;
	res_t   want_res;

	bitmap_window_sort_core #(
		.MAP_BITS (MAP_BITS),
		.WORD_BITS(WORD_BITS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	// Mostly short idle stretches, now and then a long one.
	function automatic int idle_length();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			return $urandom_range(20, 60);
		if (pick <= 3)
			return $urandom_range(4, 12);
		return $urandom_range(1, 3);
	endfunction

	function automatic void clear_model();
		foreach (map_model[w])
			map_model[w] = '0;
		cursor_model = 0;
	endfunction

	// Finds the lowest present bit at or after start, walking the map a word at a time.
	function automatic bit next_present(input int unsigned start, output int unsigned idx);
		bit [WORD_BITS-1:0] bits;
		idx = 0;
		if (start >= MAP_BITS)
			return 1'b0;
		for (int unsigned w = start / WORD_BITS; w < MAP_WORDS; w++) begin
			bits = map_model[w];
			// In the first word, bits below the cursor were already drained.
			if (w == start / WORD_BITS)
				bits = bits & ({WORD_BITS{1'b1}} << (start % WORD_BITS));
			if (bits != '0) begin
				for (int b = 0; b < WORD_BITS; b++) begin
					if (bits[b]) begin
						idx = w * WORD_BITS + b;
						return 1'b1;
					end
				end
			end
		end
		return 1'b0;
	endfunction

	// Applies one accepted request to the predicted state and queues the drain result, if
	// any. Returns 1 when the request had an effect, so that ignored ones are not counted.
	function automatic bit apply_request(input req_t r);
		logic [31:0] offset;
		int unsigned idx;
		res_t outcome;
		case (r.opcode)
			OP_INSERT: begin
				// The offset wraps modulo 2**32, so a window near the top of the range
				// continues at zero.
				offset = r.value - base_model;
				if (offset < MAP_BITS) begin
					map_model[offset / WORD_BITS][offset % WORD_BITS] = 1'b1;
					return 1'b1;
				end
				return 1'b0;
			end
			OP_DRAIN: begin
				if (next_present(cursor_model, idx)) begin
					outcome.sorted_value = base_model + idx;
					outcome.done_res     = 1'b0;
					cursor_model         = idx + 1;
				end else begin
					outcome.sorted_value = '0;
					outcome.done_res     = 1'b1;
					cursor_model         = MAP_BITS;
				end
				drain_results_q.push_back(outcome);
				return 1'b1;
			end
			OP_CLEAR: begin
				clear_model();
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// Presents one request at a falling edge and holds it until the core takes it. Starts and
	// ends at a falling edge. The valid line stays high into the next request unless a gap
	// is drawn, so back-to-back requests are exercised too.
	task automatic send_request(input logic [1:0] opcode, input logic [31:0] value);
		req_t item;
		int gap;
		item.opcode = opcode;
		item.value  = value;
		gap = (req_throttle && $urandom_range(0, 2) == 0) ? idle_length() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!req_ready);
		if (apply_request(item))
			request_count++;
		@(negedge clk);
	endtask

	// Stops sending and waits until every drain result is back and any trailing insert,
	// clear or reset sweep has finished, so the core is idle. Called at a falling edge.
	task automatic settle();
		req_valid <= 1'b0;
		while (drain_results_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		while (!req_ready)
			@(negedge clk);
	endtask

	// The window base is only moved while the core has nothing in flight.
	task automatic write_base(input logic [31:0] base);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= base;
		@(posedge clk);
		base_model = base;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Result side: ready is dropped for random stretches, but only while throttling is on.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			res_ready <= 1'b0;
			stall_left--;
		end else begin
			res_ready <= 1'b1;
			if (res_throttle && $urandom_range(0, 3) == 0)
				stall_left = idle_length();
		end
	end

	// Every result that is taken must match the oldest outstanding drain, field by field.
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (drain_results_q.size() == 0) begin
				$display("%0t: result with no drain outstanding: sorted_value %h done_res %b",
					$time, res.sorted_value, res.done_res);
				error_count++;
			end else begin
				want_res = drain_results_q.pop_front();
				if (res.sorted_value !== want_res.sorted_value) begin
					$display("%0t: sorted_value expected %h, got %h",
						$time, want_res.sorted_value, res.sorted_value);
					error_count++;
				end
				if (res.done_res !== want_res.done_res) begin
					$display("%0t: done_res expected %b, got %b",
						$time, want_res.done_res, res.done_res);
					error_count++;
				end
			end
		end
	end

	// A hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Window at zero: drains on an empty map, both ends of the window, values just past it,
	// duplicates, the unused opcode, and an insert that lands below the cursor.
	task automatic test_window_edges();
		write_base(32'h0000_0000);
		// The first drain scans the whole empty map, the second finds it already exhausted.
		send_request(OP_DRAIN, 32'hFFFF_FFFF);
		send_request(OP_DRAIN, 32'h0000_0000);
		send_request(OP_CLEAR, 32'hA5A5_A5A5);
		send_request(OP_INSERT, 32'd0);
		send_request(OP_INSERT, MAP_BITS - 1);
		send_request(OP_INSERT, MAP_BITS);
		send_request(OP_INSERT, 32'hFFFF_FFFF);
		send_request(OP_INSERT, 32'd0);
		send_request(OP_INSERT, 32'd1000);
		send_request(OP_UNUSED, 32'd7);
		send_request(OP_DRAIN, 32'd0);
		send_request(OP_DRAIN, 32'd0);
		// The cursor is now past 1000, so 500 is recorded but never drained in this pass.
		send_request(OP_INSERT, 32'd500);
		send_request(OP_INSERT, 32'd2000);
		repeat (4) send_request(OP_DRAIN, 32'd0);
	endtask

	// Base at the very top of the range: the window wraps through zero.
	task automatic test_wrapped_window();
		write_base(32'hFFFF_FFFF);
		send_request(OP_CLEAR, 32'h0000_0000);
		send_request(OP_INSERT, 32'hFFFF_FFFF);
		send_request(OP_INSERT, 32'h0000_0000);
		send_request(OP_INSERT, 32'h0000_FFFE);
		send_request(OP_INSERT, 32'h0000_FFFF);
		send_request(OP_INSERT, 32'hFFFF_FFFE);
		send_request(OP_UNUSED, 32'hFFFF_FFFF);
		repeat (4) send_request(OP_DRAIN, 32'hFFFF_FFFF);
	endtask

	// Moving the base in the middle of a pass changes the values reported for bits already set.
	task automatic test_base_move_mid_pass();
		write_base(32'd1000);
		send_request(OP_CLEAR, 32'd0);
		send_request(OP_INSERT, 32'd1000);
		send_request(OP_INSERT, 32'd1100);
		send_request(OP_INSERT, 32'd1200);
		send_request(OP_DRAIN, 32'd0);
		write_base(32'd2000);
		send_request(OP_DRAIN, 32'd0);
		send_request(OP_INSERT, 32'd2150);
		repeat (3) send_request(OP_DRAIN, 32'd0);
	endtask

	// Random sort passes: pick a window, clear, insert a batch clustered in a span of the
	// window with some noise, then drain it all out with a few late inserts mixed in.
	task automatic test_random_passes(input int target);
		logic [31:0] base;
		logic [31:0] last_value;
		int span;
		int inserts;
		last_value = '0;
		while (request_count < target) begin
			req_throttle = ($urandom_range(0, 3) != 0);
			res_throttle = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 7))
				0: base = 32'h0000_0000;
				1: base = 32'hFFFF_FFFF;
				2: base = 32'hFFFF_FFFF - $urandom_range(0, 2 * MAP_BITS);
				default: base = $urandom;
			endcase
			// Some passes reuse the previous window.
			if ($urandom_range(0, 4) != 0)
				write_base(base);
			send_request(OP_CLEAR, $urandom);
			// Narrow spans keep the scans short; the widest one pokes past the window top.
			case ($urandom_range(0, 3))
				0: span = WORD_BITS;
				1: span = 16 * WORD_BITS;
				2: span = MAP_BITS;
				default: span = MAP_BITS + MAP_BITS / 8;
			endcase
			inserts = $urandom_range(4, 40);
			repeat (inserts) begin
				case ($urandom_range(0, 19))
					0: send_request(OP_UNUSED, $urandom);
					1: send_request(OP_INSERT, $urandom);
					2: send_request(OP_INSERT, last_value);
					default: begin
						last_value = base_model + $urandom_range(0, span - 1);
						send_request(OP_INSERT, last_value);
					end
				endcase
			end
			// A couple of extra drains past the last value check the done flag.
			repeat (inserts + $urandom_range(0, 2)) begin
				case ($urandom_range(0, 29))
					0: write_base($urandom);
					1: settle();
					2, 3: send_request(OP_INSERT, base_model + $urandom_range(0, span - 1));
					default: ;
				endcase
				send_request(OP_DRAIN, $urandom);
			end
		end
	endtask

	initial begin
		clear_model();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_window_edges();
		test_wrapped_window();
		test_base_move_mid_pass();
		test_random_passes(request_count + RANDOM_REQUESTS);

		settle();
		repeat (64) @(negedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
